// ===== rtl/multi_pattern_match_counter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Multi-pattern match counter: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_MATCH_COUNTER_CORE_DEFINES_SVH
`define MULTI_PATTERN_MATCH_COUNTER_CORE_DEFINES_SVH

// check out of reset
`define MPMC_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check at every edge, reset included
`define MPMC_ASSERT_ALWAYS(lbl, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-pattern match counter: package
// Register map, item kinds and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mpmc_pkg;

	localparam int NUM_PATTERN_REGS = 4;
	localparam int PATTERN_W        = 64;
	localparam int LEN_FIELD_W      = 4;
	localparam int LENGTHS_W        = NUM_PATTERN_REGS * LEN_FIELD_W;
	localparam int IN_USE_W         = 3;
	localparam int REG_INDEX_W      = 3;
	localparam int CHAR_W           = 8;
	localparam int OUT_COUNT_W      = 32;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_PATTERN_0 = 3'd0,
		REG_PATTERN_1 = 3'd1,
		REG_PATTERN_2 = 3'd2,
		REG_PATTERN_3 = 3'd3,
		REG_LENGTHS   = 3'd4,
		REG_IN_USE    = 3'd5
	} reg_index_t;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	typedef struct packed {
		logic [NUM_PATTERN_REGS-1:0][PATTERN_W-1:0] pattern;
		logic [LENGTHS_W-1:0]                       lengths;
		logic [IN_USE_W-1:0]                        in_use;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/mpmc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Multi-pattern match counter: configuration registers
// Decodes the write port into pattern words, lengths and pattern count.
// ----------------------------------------------------------------------------
`default_nettype none

module mpmc_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [mpmc_pkg::REG_INDEX_W-1:0]    wr_index,
	input  wire logic [mpmc_pkg::PATTERN_W-1:0]      wr_data,
	output mpmc_pkg::cfg_t                           cfg
);

	mpmc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				mpmc_pkg::REG_PATTERN_0, mpmc_pkg::REG_PATTERN_1,
				mpmc_pkg::REG_PATTERN_2, mpmc_pkg::REG_PATTERN_3: begin
					cfg_q.pattern[wr_index[1:0]] <= wr_data;
				end
				mpmc_pkg::REG_LENGTHS: begin
					cfg_q.lengths <= wr_data[mpmc_pkg::LENGTHS_W-1:0];
				end
				mpmc_pkg::REG_IN_USE: begin
					cfg_q.in_use <= wr_data[mpmc_pkg::IN_USE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/mpmc_matcher.sv =====
// ----------------------------------------------------------------------------
// Multi-pattern match counter: pattern comparator
// Checks whether one pattern ends on the newest character of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module mpmc_matcher #(
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int VH_W              = 3
) (
	input  wire logic [mpmc_pkg::PATTERN_W-1:0]   pattern,
	input  wire logic [mpmc_pkg::LEN_FIELD_W-1:0] len_raw,
	input  wire logic [mpmc_pkg::CHAR_W-1:0]      window [MAX_PATTERN_BYTES],
	input  wire logic [VH_W-1:0]                  valid_count,
	output logic                                  hit
);

	localparam int IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam logic [mpmc_pkg::LEN_FIELD_W-1:0] MAXB_L =
		mpmc_pkg::LEN_FIELD_W'(MAX_PATTERN_BYTES);

	logic [mpmc_pkg::LEN_FIELD_W-1:0] len;
	logic [mpmc_pkg::LEN_FIELD_W-1:0] idx;
	logic                             bytes_ok;

	always_comb begin
		len      = (len_raw > MAXB_L) ? MAXB_L : len_raw;
		bytes_ok = 1'b1;
		idx      = '0;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			idx = len - mpmc_pkg::LEN_FIELD_W'(k + 1);
			if (mpmc_pkg::LEN_FIELD_W'(k) < len) begin
				if (pattern[8*k +: 8] != window[idx[IW-1:0]]) begin
					bytes_ok = 1'b0;
				end
			end
		end
		if (len == '0) begin
			hit = 1'b1;
		end else begin
			hit = bytes_ok &&
				(mpmc_pkg::LEN_FIELD_W'(valid_count) >= (len - 1'b1));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/multi_pattern_match_counter_core.sv =====
// ----------------------------------------------------------------------------
// Multi-pattern match counter core
// Counts start positions of configured patterns in a character stream.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries one character, s_tuser the item kind
// (0 = character, 1 = end of string). A zero character is taken and dropped.
// Output stream: one transaction per end of string, m_tdata the match count,
// m_tuser set when the count saturated.
// Configuration: wr_en/wr_index/wr_data write pattern words 0..3, the packed
// lengths and the number of patterns in use; write only while idle.
// Throughput: one item per cycle while no end of string is held. Each item
// sits in the input register, where all pattern comparators and the count
// adder act on it. Result path: an accepted end of string passes the input
// register and then the output register, which drives m_tvalid.
// Stall: while m_tready is low a waiting result holds; characters keep
// flowing, and an end of string waits in the input register, which then
// drops s_tready.
// Reset: clears patterns, lengths, history, count and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_match_counter_core #(
	parameter int NUM_PATTERNS      = 4,
	parameter int MAX_PATTERN_BYTES = 8,
	parameter int COUNT_BITS        = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [mpmc_pkg::CHAR_W-1:0]          s_tdata,   // character
	input  wire logic                                 s_tuser,   // kind
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [mpmc_pkg::OUT_COUNT_W-1:0]          m_tdata,   // match_count
	output logic                                      m_tuser,   // saturated
	input  wire logic                                 wr_en,
	input  wire logic [mpmc_pkg::REG_INDEX_W-1:0]     wr_index,
	input  wire logic [mpmc_pkg::PATTERN_W-1:0]       wr_data
);

	localparam int NP         = (NUM_PATTERNS < mpmc_pkg::NUM_PATTERN_REGS) ?
		NUM_PATTERNS : mpmc_pkg::NUM_PATTERN_REGS;
	localparam int HIST_DEPTH = MAX_PATTERN_BYTES - 1;
	localparam int HIST_N     = (HIST_DEPTH > 0) ? HIST_DEPTH : 1;
	localparam int VH_W       = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int INC_W      = $clog2(NP + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [mpmc_pkg::OUT_COUNT_W-1:0] OUT_MAX =
		mpmc_pkg::OUT_COUNT_W'(CNT_MAX);

	mpmc_pkg::cfg_t cfg;

	logic                         in_valid_s1;
	logic                         in_kind_s1;
	logic [mpmc_pkg::CHAR_W-1:0]  in_char_s1;

	logic [mpmc_pkg::CHAR_W-1:0]  hist_q [HIST_N];
	logic [VH_W-1:0]              vh_q;
	logic [COUNT_BITS-1:0]        cnt_q;
	logic                         sat_q;

	logic                              out_valid_s2;
	logic [mpmc_pkg::OUT_COUNT_W-1:0]  out_count_s2;
	logic                              out_sat_s2;

	logic [mpmc_pkg::CHAR_W-1:0]  window [MAX_PATTERN_BYTES];
	logic [NP-1:0]                hit;
	logic [mpmc_pkg::IN_USE_W-1:0] n_active;
	logic [INC_W-1:0]             inc;
	logic [COUNT_BITS:0]          sum;
	logic                         is_char;
	logic                         is_eos;
	logic                         s1_go;

	mpmc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	always_comb begin
		window[0] = in_char_s1;
		for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
			window[j] = hist_q[j-1];
		end
	end

	for (genvar p = 0; p < NP; p++) begin : g_match
		mpmc_matcher #(
			.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
			.VH_W              (VH_W)
		) u_match (
			.pattern     (cfg.pattern[p]),
			.len_raw     (cfg.lengths[mpmc_pkg::LEN_FIELD_W*p +: mpmc_pkg::LEN_FIELD_W]),
			.window      (window),
			.valid_count (vh_q),
			.hit         (hit[p])
		);
	end

	always_comb begin
		n_active = (cfg.in_use > mpmc_pkg::IN_USE_W'(NP)) ?
			mpmc_pkg::IN_USE_W'(NP) : cfg.in_use;
		inc = '0;
		for (int p = 0; p < NP; p++) begin
			if (hit[p] && (mpmc_pkg::IN_USE_W'(p) < n_active)) begin
				inc = inc + 1'b1;
			end
		end
		sum     = {1'b0, cnt_q} + (COUNT_BITS+1)'(inc);
		is_char = in_valid_s1 && (in_kind_s1 == mpmc_pkg::KIND_CHAR) && (in_char_s1 != '0);
		is_eos  = in_valid_s1 && (in_kind_s1 == mpmc_pkg::KIND_EOS);
		s1_go   = in_valid_s1 && (!is_eos || !out_valid_s2 || m_tready);
	end

	assign s_tready = !in_valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			in_kind_s1   <= mpmc_pkg::KIND_CHAR;
			in_char_s1   <= '0;
			vh_q         <= '0;
			cnt_q        <= '0;
			sat_q        <= 1'b0;
			out_valid_s2 <= 1'b0;
			out_count_s2 <= '0;
			out_sat_s2   <= 1'b0;
			for (int i = 0; i < HIST_N; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
				in_kind_s1  <= s_tuser;
				in_char_s1  <= s_tdata;
			end

			if (s1_go && is_eos) begin
				out_valid_s2 <= 1'b1;
				out_count_s2 <= mpmc_pkg::OUT_COUNT_W'(cnt_q);
				out_sat_s2   <= sat_q;
			end else if (m_tready) begin
				out_valid_s2 <= 1'b0;
			end

			if (s1_go && is_eos) begin
				vh_q  <= '0;
				cnt_q <= '0;
				sat_q <= 1'b0;
				for (int i = 0; i < HIST_N; i++) begin
					hist_q[i] <= '0;
				end
			end else if (is_char) begin
				if (sum[COUNT_BITS]) begin
					cnt_q <= CNT_MAX;
					sat_q <= 1'b1;
				end else begin
					cnt_q <= sum[COUNT_BITS-1:0];
				end
				if (HIST_DEPTH > 0) begin
					hist_q[0] <= in_char_s1;
					for (int i = 1; i < HIST_N; i++) begin
						hist_q[i] <= hist_q[i-1];
					end
					if (vh_q < VH_W'(HIST_DEPTH)) begin
						vh_q <= vh_q + 1'b1;
					end
				end
			end
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_count_s2;
	assign m_tuser  = out_sat_s2;

`include "multi_pattern_match_counter_core_defines.svh"

	`MPMC_ASSERT(a_sat_at_max, sat_q |-> (cnt_q == CNT_MAX), "saturated count below max")
	`MPMC_ASSERT(a_sat_out_max, (m_tvalid && m_tuser) |-> (m_tdata == OUT_MAX),
		"saturated result not at max")
	`MPMC_ASSERT(a_eos_clears, (s1_go && is_eos) |=> ((cnt_q == '0) && !sat_q && (vh_q == '0)),
		"string state not cleared after end of string")
	`MPMC_ASSERT(a_hist_bound, vh_q <= VH_W'(HIST_DEPTH), "history count out of range")

endmodule

`default_nettype wire

// ===== verif/multi_pattern_match_counter_core_checker.sv =====
// ----------------------------------------------------------------------------
// Multi-pattern match counter: stream checker
// Watches the configuration port and both streams, keeps its own copy of the
// patterns and of the per-string history, predicts the match count of every
// finished string and compares each output transaction against it.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_match_counter_core_checker
	import mpmc_pkg::*;
#(
	parameter int NUM_PATTERNS      = 4,
	parameter int MAX_PATTERN_BYTES = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [CHAR_W-1:0]      s_tdata,   // character
	input  wire logic                   s_tuser,   // kind
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_COUNT_W-1:0] m_tdata,   // match_count
	input  wire logic                   m_tuser,   // saturated
	input  wire logic                   wr_en,
	input  wire logic [REG_INDEX_W-1:0] wr_index,
	input  wire logic [PATTERN_W-1:0]   wr_data,
	output int                          fail_count,
	output int                          pending_tallies,
	output int                          tallies_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SUM_W = OUT_COUNT_W + 1;
	localparam int HISTORY_DEPTH = MAX_PATTERN_BYTES - 1;
	localparam logic [OUT_COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] count;
		logic                   saturated;
	} tally_t;

	cfg_t                   cfg;
	logic [CHAR_W-1:0]      history [HISTORY_DEPTH];
	int                     history_fill;
	logic [OUT_COUNT_W-1:0] run_count;
	logic                   run_saturated;
	tally_t                 tally_q [$];
	int                     errors;
	int                     checked;

	task automatic clear_string();
		for (int i = 0; i < HISTORY_DEPTH; i++) history[i] = '0;
		history_fill = 0;
		run_count = '0;
		run_saturated = 1'b0;
	endtask

	function automatic int pattern_length(int p);
		int len;
		len = int'(cfg.lengths[p*LEN_FIELD_W +: LEN_FIELD_W]);
		if (len > MAX_PATTERN_BYTES) len = MAX_PATTERN_BYTES;
		return len;
	endfunction

	function automatic logic pattern_ends(int p, logic [CHAR_W-1:0] c);
		int len;
		logic [CHAR_W-1:0] want;
		logic [CHAR_W-1:0] have;
		len = pattern_length(p);
		if (len == 0) return 1'b1;
		if (history_fill < len - 1) return 1'b0;
		for (int j = 0; j < len; j++) begin
			want = cfg.pattern[p][CHAR_W*(len-1-j) +: CHAR_W];
			have = (j == 0) ? c : history[j-1];
			if (want != have) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic take_item(logic kind, logic [CHAR_W-1:0] c);
		int active;
		int hits;
		logic [SUM_W-1:0] sum;
		if (kind == KIND_EOS) begin
			tally_q.push_back('{count: run_count, saturated: run_saturated});
			clear_string();
		end else if (c != '0) begin
			active = int'(cfg.in_use);
			if (active > NUM_PATTERNS) active = NUM_PATTERNS;
			if (active > NUM_PATTERN_REGS) active = NUM_PATTERN_REGS;
			hits = 0;
			for (int p = 0; p < active; p++)
				if (pattern_ends(p, c)) hits++;
			sum = {1'b0, run_count} + SUM_W'(hits);
			if (sum > {1'b0, COUNT_MAX}) begin
				run_count = COUNT_MAX;
				run_saturated = 1'b1;
			end else begin
				run_count = sum[OUT_COUNT_W-1:0];
			end
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
			history[0] = c;
			if (history_fill < HISTORY_DEPTH) history_fill++;
		end
	endtask

	task automatic check_tally();
		tally_t want;
		checked++;
		if (tally_q.size() == 0) begin
			$error("match_count: no string closed, got %0d (saturated %0b)", m_tdata, m_tuser);
			errors++;
		end else begin
			want = tally_q.pop_front();
			if (m_tdata !== want.count) begin
				$error("match_count: expected %0d, got %0d", want.count, m_tdata);
				errors++;
			end
			if (m_tuser !== want.saturated) begin
				$error("saturated: expected %0b, got %0b", want.saturated, m_tuser);
				errors++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg = '0;
			clear_string();
			tally_q.delete();
			errors = 0;
			checked = 0;
		end else begin
			if (m_tvalid && m_tready) check_tally();
			if (s_tvalid && s_tready) take_item(s_tuser, s_tdata);
			if (wr_en) begin
				case (reg_index_t'(wr_index))
					REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
						cfg.pattern[wr_index[1:0]] = wr_data;
					end
					REG_LENGTHS: begin
						cfg.lengths = wr_data[LENGTHS_W-1:0];
					end
					REG_IN_USE: begin
						cfg.in_use = wr_data[IN_USE_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
		fail_count <= errors;
		pending_tallies <= tally_q.size();
		tallies_checked <= checked;
	end

endmodule

`default_nettype wire

// ===== verif/multi_pattern_match_counter_core_test.sv =====
// ----------------------------------------------------------------------------
// Multi-pattern match counter: testbench top
// Drives directed and random strings through the core under changing pattern
// setups, with random gaps on both streams, a long output hold-off and full
// drains; the checker beside the core predicts and compares every count.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_match_counter_core_test;

	import mpmc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int RANDOM_ITEMS   = 450;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 10;
	localparam int HOLD_CYCLES    = 120;
	localparam int LIMIT_CYCLES   = 400000;
	localparam int MAX_BYTES      = 8;
	localparam int HOLD_PHASE     = 3;
	localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_B = 8'h62;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [CHAR_W-1:0]      s_tdata = '0;   // character
	logic                   s_tuser = 1'b0; // kind
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_COUNT_W-1:0] m_tdata;        // match_count
	logic                   m_tuser;        // saturated
	logic                   wr_en = 1'b0;
	logic [REG_INDEX_W-1:0] wr_index = '0;
	logic [PATTERN_W-1:0]   wr_data = '0;

	int fail_count;
	int pending_tallies;
	int tallies_checked;

	logic [PATTERN_W-1:0] cur_words [NUM_PATTERN_REGS];
	logic [LENGTHS_W-1:0] cur_lengths;
	logic [IN_USE_W-1:0]  cur_in_use;

	bit src_gaps    = 1'b0;
	bit sink_stalls = 1'b0;
	bit sink_hold   = 1'b0;
	int items_sent  = 0;
	int strings_sent = 0;
	int setups      = 0;
	int cycle_count = 0;

	multi_pattern_match_counter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	multi_pattern_match_counter_core_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.fail_count      (fail_count),
		.pending_tallies (pending_tallies),
		.tallies_checked (tallies_checked)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int gap_length();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// output side: random stalls, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold = 1'b0;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_length()) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d counts still due", cycle_count, pending_tallies);
		$display("** multi_pattern_match_counter_core: FAILED **");
		$finish;
	end

	task automatic send_item(logic kind, logic [CHAR_W-1:0] c);
		int gap;
		gap = 0;
		if (src_gaps && $urandom_range(0, 1) == 0) gap = gap_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= CHAR_W'($urandom);
			s_tuser <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == KIND_EOS || c != '0) items_sent++;
	endtask

	// drop valid and wait until every count has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_tallies != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure();
		for (int i = 0; i < NUM_PATTERN_REGS; i++) begin
			wr_en <= 1'b1;
			wr_index <= reg_index_t'(int'(REG_PATTERN_0) + i);
			wr_data <= cur_words[i];
			@(posedge clk);
		end
		wr_en <= 1'b1;
		wr_index <= REG_LENGTHS;
		wr_data <= PATTERN_W'(cur_lengths);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_IN_USE;
		wr_data <= PATTERN_W'(cur_in_use);
		@(posedge clk);
		wr_en <= 1'b0;
		setups++;
	endtask

	function automatic logic [CHAR_W-1:0] pattern_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 8'h00;
		if (r < 8) return 8'hFF;
		if (r < 15) return CHAR_W'($urandom);
		return CHAR_A + CHAR_W'($urandom_range(0, 2));
	endfunction

	task automatic random_setup();
		int len;
		for (int p = 0; p < NUM_PATTERN_REGS; p++) begin
			for (int b = 0; b < MAX_BYTES; b++) cur_words[p][CHAR_W*b +: CHAR_W] = pattern_byte();
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
			cur_lengths[p*LEN_FIELD_W +: LEN_FIELD_W] = LEN_FIELD_W'(len);
		end
		cur_in_use = ($urandom_range(0, 2) == 0) ? IN_USE_W'($urandom) : IN_USE_W'(4);
	endtask

	function automatic logic [CHAR_W-1:0] string_char();
		int r;
		int p;
		int b;
		r = $urandom_range(0, 99);
		p = $urandom_range(0, NUM_PATTERN_REGS - 1);
		b = $urandom_range(0, MAX_BYTES - 1);
		if (r < 4) return 8'h00;
		if (r < 18) return CHAR_W'($urandom_range(1, 255));
		if (r < 35) return cur_words[p][CHAR_W*b +: CHAR_W];
		return CHAR_A + CHAR_W'($urandom_range(0, 2));
	endfunction

	task automatic send_pattern(int p);
		int len;
		len = int'(cur_lengths[p*LEN_FIELD_W +: LEN_FIELD_W]);
		if (len > MAX_BYTES) len = MAX_BYTES;
		for (int k = 0; k < len; k++) send_item(KIND_CHAR, cur_words[p][CHAR_W*k +: CHAR_W]);
	endtask

	task automatic send_random_string();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 10);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) send_pattern($urandom_range(0, NUM_PATTERN_REGS - 1));
			else send_item(KIND_CHAR, string_char());
		end
		send_item(KIND_EOS, CHAR_W'($urandom));
		strings_sent++;
	endtask

	initial begin
		int phase;
		@(posedge arst_n);
		@(posedge clk);

		// reset setup: no pattern in use
		send_item(KIND_CHAR, CHAR_A);
		send_item(KIND_EOS, 8'h00);
		settle();

		cur_words[0] = 64'h6261;
		cur_words[1] = '1;
		cur_words[2] = '1;
		cur_words[3] = 64'h0061;
		cur_lengths = 16'h2F02;
		cur_in_use = 3'd7;
		configure();
		send_item(KIND_CHAR, CHAR_A);
		send_item(KIND_CHAR, CHAR_B);
		send_item(KIND_CHAR, CHAR_A);
		send_item(KIND_CHAR, 8'h00);
		send_item(KIND_CHAR, CHAR_B);
		repeat (MAX_BYTES) send_item(KIND_CHAR, 8'hFF);
		send_item(KIND_EOS, 8'hFF);
		send_item(KIND_EOS, 8'h00);
		send_item(KIND_CHAR, 8'h01);
		send_item(KIND_CHAR, 8'h80);
		send_item(KIND_CHAR, 8'h7F);
		send_item(KIND_EOS, 8'h5A);
		strings_sent += 4;

		// change the setup in the middle of a string
		send_item(KIND_CHAR, CHAR_A);
		settle();
		cur_words[1] = '0;
		cur_lengths = 16'h0012;
		cur_in_use = 3'd2;
		configure();
		send_item(KIND_CHAR, CHAR_B);
		send_item(KIND_EOS, 8'h00);
		strings_sent++;

		items_sent = 0;
		phase = 0;
		while (items_sent < RANDOM_ITEMS || phase <= HOLD_PHASE) begin
			settle();
			if (phase == 1) begin
				for (int p = 0; p < NUM_PATTERN_REGS; p++) cur_words[p] = '1;
				cur_lengths = '1;
				cur_in_use = '1;
			end else if (phase == 2) begin
				cur_lengths = '0;
				cur_in_use = '0;
			end else begin
				random_setup();
			end
			configure();
			src_gaps = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			if (phase == HOLD_PHASE) begin
				src_gaps = 1'b0;
				sink_hold = 1'b1;
			end
			repeat ($urandom_range(4, 10)) send_random_string();
			phase++;
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d strings under %0d pattern setups; %0d counts compared.",
			strings_sent, setups, tallies_checked);
		$display("Setups spanned unused, empty, over-long, zero-byte and all-ones patterns.");
		if (fail_count == 0 && pending_tallies == 0)
			$display("** multi_pattern_match_counter_core: PASSED **");
		else
			$display("** multi_pattern_match_counter_core: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
